// ===== rtl/core/mwsk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mwsk_pkg;

  // field and datapath widths
  localparam int VelW    = 16;
  localparam int CordW   = 27;  // rotation vector, velocity times 256 plus growth
  localparam int AngW    = 32;  // angle accumulator, 32 bits per turn
  localparam int GainW   = 17;
  localparam int YawW    = 33;
  localparam int SumW    = 37;  // wheel sum at Q.28
  localparam int ProdW   = 54;  // wheel sum times inverse radius at Q.36
  localparam int RndW    = 26;
  localparam int WheelW  = 24;
  localparam int CfgIdxW = 1;

  // 1/K of the rotation, Q0.16
  localparam logic signed [GainW-1:0] GainInv = 17'sd39797;

  localparam logic signed [RndW-1:0] WheelMax = 26'sd8388607;
  localparam logic signed [RndW-1:0] WheelMin = -26'sd8388608;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLeverLength   = 1'b0,
    CfgInverseRadius = 1'b1
  } cfg_idx_e;

  // one beat moving down the rotation chain
  typedef struct packed {
    logic                    valid;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic signed [VelW-1:0]  wz;
  } cordic_beat_t;

  // arctangent of 2^-idx, 32 bits per turn, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_turn32(input int idx);
    logic signed [AngW-1:0] a;
    case (idx)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10679838;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41722;
      15:      a = 32'sd20861;
      16:      a = 32'sd10430;
      17:      a = 32'sd5215;
      18:      a = 32'sd2608;
      19:      a = 32'sd1304;
      20:      a = 32'sd652;
      21:      a = 32'sd326;
      22:      a = 32'sd163;
      23:      a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mwsk_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mwsk_cordic_cell #(
  parameter int Shift = 0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  mwsk_pkg::cordic_beat_t beat_i,
  output mwsk_pkg::cordic_beat_t beat_o
);
  import mwsk_pkg::*;

  localparam logic signed [AngW-1:0] Atan = atan_turn32(Shift);

  cordic_beat_t            beat_d, beat_q;
  logic signed [CordW-1:0] dx, dy;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    dx     = beat_i.y >>> Shift;
    dy     = beat_i.x >>> Shift;
    beat_d = beat_i;
    if (!beat_i.z[AngW-1]) begin
      beat_d.x = beat_i.x - dx;
      beat_d.y = beat_i.y + dy;
      beat_d.z = beat_i.z - Atan;
    end else begin
      beat_d.x = beat_i.x + dx;
      beat_d.y = beat_i.y - dy;
      beat_d.z = beat_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q.valid <= 1'b0;
    end else if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

`default_nettype wire

// ===== rtl/core/mwsk_wheel_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mwsk_wheel_lane #(
  parameter bit NegYaw = 1'b0,
  parameter bit NegVy  = 1'b0
) (
  input  wire                                     clk_i,
  input  wire                                     en_i,
  input  wire signed [mwsk_pkg::CordW-1:0]        vxb_i,
  input  wire signed [mwsk_pkg::CordW-1:0]        vyb_i,
  input  wire signed [mwsk_pkg::YawW-1:0]         yaw_i,
  input  wire        [15:0]                       inv_radius_i,
  output logic signed [mwsk_pkg::WheelW-1:0]      speed_o,
  output logic                                    clip_o
);
  import mwsk_pkg::*;

  localparam logic signed [ProdW-1:0] RoundHalf = 54'sd134217728;

  logic signed [SumW-1:0]   vx_e, vy_e, yaw_e;
  logic signed [SumW-1:0]   sum_d, sum_q;
  logic signed [ProdW-1:0]  prod_d, prod_q, rnd_full;
  logic signed [RndW-1:0]   rnd;
  logic signed [WheelW-1:0] speed_d, speed_q;
  logic                     clip_d, clip_q;

  // wheel sum at Q.28
  always_comb begin
    vx_e  = SumW'($signed({vxb_i, 8'h00}));
    vy_e  = SumW'($signed({vyb_i, 8'h00}));
    yaw_e = SumW'(yaw_i);
    sum_d = vx_e + (NegVy ? -vy_e : vy_e) + (NegYaw ? -yaw_e : yaw_e);
  end

  // scale by inverse radius
  assign prod_d = sum_q * $signed({1'b0, inv_radius_i});

  // round half up to Q16.8 and saturate
  always_comb begin
    rnd_full = prod_q + RoundHalf;
    rnd      = rnd_full[ProdW-1:ProdW-RndW];
    clip_d   = 1'b0;
    speed_d  = rnd[WheelW-1:0];
    if (rnd > WheelMax) begin
      speed_d = WheelMax[WheelW-1:0];
      clip_d  = 1'b1;
    end else if (rnd < WheelMin) begin
      speed_d = WheelMin[WheelW-1:0];
      clip_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      prod_q  <= prod_d;
      speed_q <= speed_d;
      clip_q  <= clip_d;
    end
  end

  assign speed_o = speed_q;
  assign clip_o  = clip_q;

endmodule

`default_nettype wire

// ===== rtl/core/mecanum_wheel_speed_kinematics.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-wheel mecanum inverse kinematics. Each input beat (heading, yaw rate,
// world-frame vx/vy) rotates the velocity into the body frame through a chain
// of ANGLE_STAGES CORDIC cells, removes the rotation gain, and forms the four
// wheel speeds (+-wz*L + vx +- vy)*invR in signed Q16.8 with saturation and
// a clipped flag. The pipeline takes one beat per clock unless the output is
// stalled, then the whole pipeline holds. It registers the input pre-rotation,
// each CORDIC cell, gain multiply, wheel sum, radius multiply and round/saturate.
// lever_length and inverse_radius are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must write them only while no beat is in flight, the block does not enforce it.
module mecanum_wheel_speed_kinematics #(
  parameter int ANGLE_STAGES = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire        [mwsk_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire        [15:0]                     cfg_wdata_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire signed [15:0]                     heading_i,
  input  wire signed [15:0]                     yaw_rate_i,
  input  wire signed [15:0]                     vel_x_i,
  input  wire signed [15:0]                     vel_y_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [mwsk_pkg::WheelW-1:0]    wheel_speed_a_o,
  output logic signed [mwsk_pkg::WheelW-1:0]    wheel_speed_b_o,
  output logic signed [mwsk_pkg::WheelW-1:0]    wheel_speed_c_o,
  output logic signed [mwsk_pkg::WheelW-1:0]    wheel_speed_d_o,
  output logic                                  clipped_o
);
  import mwsk_pkg::*;

  logic [15:0] lever_q, inv_radius_q;
  logic        en;

  cordic_beat_t pre_d;
  cordic_beat_t beat [ANGLE_STAGES+1];
  logic [AngW-1:0] zu;

  logic signed [CordW+GainW-1:0] gx_full, gy_full, gx_rnd, gy_rnd;
  logic signed [CordW-1:0]       vxb_q, vyb_q;
  logic signed [YawW-1:0]        yaw_d, yaw_q;
  logic [3:0]                    post_valid_q;
  logic [3:0]                    lane_clip;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lever_q      <= 16'd14408;
      inv_radius_q <= 16'd5120;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgLeverLength:   lever_q      <= cfg_wdata_i;
        CfgInverseRadius: inv_radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output beat is stuck
  assign en         = !post_valid_q[3] || out_ready_i;
  assign in_ready_o = en;

  // negate heading into the angle, fold the left half-plane by half a turn
  always_comb begin
    zu          = AngW'(0) - {heading_i, 16'h0000};
    pre_d.valid = in_valid_i;
    pre_d.wz    = yaw_rate_i;
    pre_d.x     = $signed({{3{vel_x_i[15]}}, vel_x_i, 8'h00});
    pre_d.y     = $signed({{3{vel_y_i[15]}}, vel_y_i, 8'h00});
    if (zu[AngW-1] ^ zu[AngW-2]) begin
      pre_d.x     = -pre_d.x;
      pre_d.y     = -pre_d.y;
      zu[AngW-1]  = ~zu[AngW-1];
    end
    pre_d.z = $signed(zu);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat[0].valid <= 1'b0;
    end else if (en) begin
      beat[0] <= pre_d;
    end
  end

  // rotation chain
  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cell
    mwsk_cordic_cell #(
      .Shift (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (beat[i]),
      .beat_o (beat[i+1])
    );
  end

  // gain removal and yaw lever term
  always_comb begin
    gx_full = beat[ANGLE_STAGES].x * GainInv;
    gy_full = beat[ANGLE_STAGES].y * GainInv;
    gx_rnd  = gx_full + 44'sd32768;
    gy_rnd  = gy_full + 44'sd32768;
    yaw_d   = beat[ANGLE_STAGES].wz * $signed({1'b0, lever_q});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vxb_q <= gx_rnd[CordW+15:16];
      vyb_q <= gy_rnd[CordW+15:16];
      yaw_q <= yaw_d;
    end
  end

  // valid bits for the post-rotation stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_valid_q <= '0;
    end else if (en) begin
      post_valid_q <= {post_valid_q[2:0], beat[ANGLE_STAGES].valid};
    end
  end

  // four wheel lanes
  mwsk_wheel_lane #(.NegYaw(1'b1), .NegVy(1'b1)) u_lane_a (
    .clk_i (clk_i), .en_i (en), .vxb_i (vxb_q), .vyb_i (vyb_q), .yaw_i (yaw_q),
    .inv_radius_i (inv_radius_q), .speed_o (wheel_speed_a_o), .clip_o (lane_clip[0])
  );
  mwsk_wheel_lane #(.NegYaw(1'b0), .NegVy(1'b0)) u_lane_b (
    .clk_i (clk_i), .en_i (en), .vxb_i (vxb_q), .vyb_i (vyb_q), .yaw_i (yaw_q),
    .inv_radius_i (inv_radius_q), .speed_o (wheel_speed_b_o), .clip_o (lane_clip[1])
  );
  mwsk_wheel_lane #(.NegYaw(1'b0), .NegVy(1'b1)) u_lane_c (
    .clk_i (clk_i), .en_i (en), .vxb_i (vxb_q), .vyb_i (vyb_q), .yaw_i (yaw_q),
    .inv_radius_i (inv_radius_q), .speed_o (wheel_speed_c_o), .clip_o (lane_clip[2])
  );
  mwsk_wheel_lane #(.NegYaw(1'b1), .NegVy(1'b0)) u_lane_d (
    .clk_i (clk_i), .en_i (en), .vxb_i (vxb_q), .vyb_i (vyb_q), .yaw_i (yaw_q),
    .inv_radius_i (inv_radius_q), .speed_o (wheel_speed_d_o), .clip_o (lane_clip[3])
  );

  assign out_valid_o = post_valid_q[3];
  assign clipped_o   = |lane_clip;

endmodule

`default_nettype wire
